// ===== hw/rtl/key_offset_ema_table_top_macros.svh =====
// assertion macros shared by the checker
`ifndef KEY_OFFSET_EMA_TABLE_TOP_MACROS_SVH
`define KEY_OFFSET_EMA_TABLE_TOP_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define KOET_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet while reset is held
`define KOET_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/koet_pkg.sv =====
package koet_pkg;

	localparam int FRAC_BITS = 8;
	localparam int MEAN_W    = 24;
	localparam int VAR_W     = 32;
	localparam int CNT_W     = 16;
	localparam int POS_W     = 13;

	typedef enum logic [1:0] {
		OP_APPLY  = 2'd0,
		OP_UPDATE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} koet_op_t;

	typedef enum logic [2:0] {
		ST_APPLIED = 3'd0,
		ST_LEARNED = 3'd1,
		ST_UPDATED = 3'd2,
		ST_SKIPPED = 3'd3,
		ST_CLEARED = 3'd4
	} koet_status_t;

	localparam logic [1:0] REG_SHIFT_ENABLE = 2'd0;
	localparam logic [1:0] REG_EMA_WEIGHT   = 2'd1;
	localparam logic [1:0] REG_SHIFT_RATIO  = 2'd2;

	typedef struct packed {
		logic        [CNT_W-1:0]  cnt;
		logic        [VAR_W-1:0]  var_y;
		logic        [VAR_W-1:0]  var_x;
		logic signed [MEAN_W-1:0] mean_y;
		logic signed [MEAN_W-1:0] mean_x;
	} koet_rec_t;

endpackage

// ===== hw/rtl/key_offset_ema_table_top.sv =====
// per-key touch offset table: apply, update and clear on a command channel
// an item is taken when start is high and busy is low; busy stays high until
// the single result has been shown for one cycle with done high
// configuration: cfg_write with cfg_index / cfg_data, only while busy is low
// the arithmetic runs through one shift-add multiplier and one restoring
// divider, both retiring one bit per cycle, plus a registered table read
// clear, skip, disabled apply and a new key with negative upstream x take no
// multiply or divide; apply of a known key multiplies each axis mean by
// shift_ratio; apply of a new key divides, 30 quotient bits per axis; update
// runs per axis three products of up to 17, 24 and 17 bits
// the next item can be accepted in the cycle after done
// reset clears every key's valid mark and loads the register defaults;
// the results cannot be held off, so done is a one-cycle strobe
module key_offset_ema_table_top #(
	parameter int KEY_SLOTS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   op,
	input  logic [5:0]                   key_index,
	input  logic signed [12:0]           centre_x,
	input  logic signed [12:0]           centre_y,
	input  logic signed [12:0]           upstream_x,
	input  logic signed [12:0]           upstream_y,
	input  logic signed [12:0]           error_x,
	input  logic signed [12:0]           error_y,
	output logic                         done,
	output logic [2:0]                   status,
	output logic signed [12:0]           out_x,
	output logic signed [12:0]           out_y,
	output logic signed [23:0]           mean_x,
	output logic signed [23:0]           mean_y,
	output logic [31:0]                  spread_x,
	output logic [31:0]                  spread_y,
	output logic [15:0]                  sample_count,
	input  logic                         cfg_write,
	input  logic [1:0]                   cfg_index,
	input  logic [16:0]                  cfg_data
);
	import koet_pkg::*;

	localparam int AW    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int PW    = 52;
	localparam int OW    = 34;
	localparam int NW    = 14 + FRAC_BITS + 8;
	localparam int DCW   = $clog2(NW + 1);
	localparam int RSH   = FRAC_BITS + 8;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RD   = 8'b0000_0010,
		S_DEC  = 8'b0000_0100,
		S_MUL  = 8'b0000_1000,
		S_DIV  = 8'b0001_0000,
		S_POST = 8'b0010_0000,
		S_WR   = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	typedef enum logic [1:0] {
		PH_MEAN = 2'd0,
		PH_SQ   = 2'd1,
		PH_VAR  = 2'd2
	} phase_t;

	state_t state_q;
	phase_t phase_q;
	logic   axis_q;
	logic   known_q;

	logic              shift_enable_q;
	logic [16:0]       ema_weight_q;
	logic [15:0]       shift_ratio_q;

	logic [KEY_SLOTS-1:0] valid_q;
	koet_rec_t            mem_q [KEY_SLOTS];
	koet_rec_t            rdata_q;

	koet_op_t          op_q;
	logic [5:0]        key_q;
	logic [AW-1:0]     addr_q;
	logic signed [12:0] cx_q, cy_q, ux_q, uy_q, ex_q, ey_q;

	logic signed [MEAN_W-1:0] mean_x_q, mean_y_q;
	logic [VAR_W-1:0]         var_x_q, var_y_q;
	logic [CNT_W-1:0]         cnt_q;
	koet_status_t             status_q;
	logic signed [12:0]       ox_q, oy_q;

	logic signed [PW-1:0] mul_a_q, mul_p_q;
	logic [23:0]          mul_b_q;

	logic [NW-1:0]   div_n_q, div_quo_q;
	logic [16:0]     div_r_q;
	logic [DCW-1:0]  div_cnt_q;
	logic            div_neg_q;

	// combinational helpers
	logic                     in_range, known_now;
	logic [16:0]              wt;
	logic [15:0]              ratio;
	logic signed [OW-1:0]     ex34, ey34, cur_e;
	logic signed [MEAN_W-1:0] cur_m;
	logic [VAR_W-1:0]         cur_v;
	logic signed [12:0]       cur_c;
	logic signed [PW-1:0]     rnd, nm_w, sq_w, nv_w, sh_w, ov_w;
	logic signed [MEAN_W-1:0] new_mean;
	logic signed [OW-1:0]     d, ad, vdiff, ey_m;
	logic [23:0]              ad24;
	logic [VAR_W-1:0]         sq, new_var;
	logic signed [12:0]       o_sat;
	logic signed [13:0]       dx, dy;
	logic [13:0]              magx, magy;
	logic [16:0]              r2;
	logic                     ge;
	logic signed [MEAN_W-1:0] learned;

	assign in_range  = 9'(key_q) < 9'(KEY_SLOTS);
	assign known_now = in_range && valid_q[addr_q];

	always_comb begin
		wt    = (ema_weight_q > 17'd65536) ? 17'd65536 : ema_weight_q;
		ratio = (shift_ratio_q == 16'd0) ? 16'd1 : shift_ratio_q;
		ex34  = signed'({{(OW-13-FRAC_BITS){ex_q[12]}}, ex_q, {FRAC_BITS{1'b0}}});
		ey34  = signed'({{(OW-13-FRAC_BITS){ey_q[12]}}, ey_q, {FRAC_BITS{1'b0}}});
		cur_e = axis_q ? ey34 : ex34;
		cur_m = axis_q ? mean_y_q : mean_x_q;
		cur_v = axis_q ? var_y_q : var_x_q;
		cur_c = axis_q ? cy_q : cx_q;

		// rounded blend step: prev + floor((a * diff + half) / 2^16)
		rnd  = (mul_p_q + PW'(33'sd32768)) >>> 16;
		nm_w = PW'(cur_m) + rnd;
		if (nm_w > PW'(25'sd8388607))
			new_mean = 24'sh7FFFFF;
		else if (nm_w < PW'(-25'sd8388608))
			new_mean = 24'sh800000;
		else
			new_mean = nm_w[MEAN_W-1:0];
		d    = cur_e - OW'(new_mean);
		ad   = d[OW-1] ? -d : d;
		ad24 = ad[23:0];

		sq_w = mul_p_q >>> FRAC_BITS;
		sq   = (sq_w > PW'(34'sd4294967295)) ? 32'hFFFF_FFFF : sq_w[VAR_W-1:0];
		vdiff = signed'({2'b00, sq}) - signed'({2'b00, cur_v});
		nv_w    = PW'(signed'({1'b0, cur_v})) + rnd;
		new_var = nv_w[VAR_W-1:0];
		ey_m    = ey34 - OW'(mean_y_q);

		// apply to a known key
		sh_w = mul_p_q >>> RSH;
		ov_w = sh_w + PW'(cur_c);
		if (ov_w > PW'(14'sd4095))
			o_sat = 13'sd4095;
		else if (ov_w < PW'(-14'sd4096))
			o_sat = -13'sd4096;
		else
			o_sat = ov_w[12:0];

		dx   = 14'(ux_q) - 14'(cx_q);
		dy   = 14'(uy_q) - 14'(cy_q);
		magx = dx[13] ? 14'(-dx) : 14'(dx);
		magy = dy[13] ? 14'(-dy) : 14'(dy);

		// restoring divide, one quotient bit a cycle
		r2 = {div_r_q[15:0], div_n_q[NW-1]};
		ge = r2 >= {1'b0, ratio};

		if (div_neg_q)
			learned = (div_quo_q > NW'(24'd8388608)) ? 24'sh800000
				: -signed'(div_quo_q[MEAN_W-1:0]);
		else
			learned = (div_quo_q > NW'(24'd8388607)) ? 24'sh7FFFFF
				: signed'(div_quo_q[MEAN_W-1:0]);
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[addr_q];
		if (state_q == S_WR)
			mem_q[addr_q] <= '{cnt: cnt_q, var_y: var_y_q, var_x: var_x_q,
				mean_y: mean_y_q, mean_x: mean_x_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_enable_q <= 1'b1;
			ema_weight_q   <= 17'd6554;
			shift_ratio_q  <= 16'd256;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SHIFT_ENABLE: shift_enable_q <= cfg_data[0];
				REG_EMA_WEIGHT:   ema_weight_q   <= cfg_data;
				REG_SHIFT_RATIO:  shift_ratio_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			known_q <= 1'b0;
			axis_q  <= 1'b0;
			phase_q <= PH_MEAN;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q   <= koet_op_t'(op);
						key_q  <= key_index;
						addr_q <= AW'(key_index);
						cx_q <= centre_x;
						cy_q <= centre_y;
						ux_q <= upstream_x;
						uy_q <= upstream_y;
						ex_q <= error_x;
						ey_q <= error_y;
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_DEC;
				S_DEC: begin
					known_q  <= known_now;
					mean_x_q <= rdata_q.mean_x;
					mean_y_q <= rdata_q.mean_y;
					var_x_q  <= rdata_q.var_x;
					var_y_q  <= rdata_q.var_y;
					cnt_q    <= rdata_q.cnt;
					axis_q   <= 1'b0;
					phase_q  <= PH_MEAN;
					ox_q     <= '0;
					oy_q     <= '0;
					status_q <= ST_SKIPPED;
					state_q  <= S_OUT;
					unique case (op_q)
						OP_APPLY: begin
							ox_q <= ux_q;
							oy_q <= uy_q;
							if (!shift_enable_q || !in_range) begin
								status_q <= known_now ? ST_APPLIED : ST_SKIPPED;
							end else if (known_now) begin
								mul_a_q <= PW'(rdata_q.mean_x);
								mul_b_q <= 24'(ratio);
								mul_p_q <= '0;
								state_q <= S_MUL;
							end else if (ux_q[12]) begin
								mean_x_q <= '0;
								mean_y_q <= '0;
								var_x_q  <= '0;
								var_y_q  <= '0;
								cnt_q    <= 16'd1;
								state_q  <= S_WR;
							end else begin
								var_x_q   <= '0;
								var_y_q   <= '0;
								cnt_q     <= 16'd1;
								div_n_q   <= {magx, {(NW-14){1'b0}}};
								div_neg_q <= dx[13];
								div_r_q   <= '0;
								div_quo_q <= '0;
								div_cnt_q <= DCW'(NW);
								state_q   <= S_DIV;
							end
						end
						OP_UPDATE: begin
							if (known_now) begin
								mul_a_q <= PW'(ex34 - OW'(rdata_q.mean_x));
								mul_b_q <= 24'(wt);
								mul_p_q <= '0;
								state_q <= S_MUL;
							end
						end
						OP_CLEAR: begin
							valid_q  <= '0;
							known_q  <= 1'b0;
							status_q <= ST_CLEARED;
						end
						default: ;
					endcase
				end
				S_MUL: begin
					if (mul_b_q == '0) begin
						state_q <= S_POST;
					end else begin
						if (mul_b_q[0])
							mul_p_q <= mul_p_q + mul_a_q;
						mul_a_q <= mul_a_q <<< 1;
						mul_b_q <= mul_b_q >> 1;
					end
				end
				S_DIV: begin
					if (div_cnt_q == '0) begin
						state_q <= S_POST;
					end else begin
						div_r_q   <= ge ? r2 - {1'b0, ratio} : r2;
						div_n_q   <= div_n_q << 1;
						div_quo_q <= {div_quo_q[NW-2:0], ge};
						div_cnt_q <= div_cnt_q - 1'b1;
					end
				end
				S_POST: begin
					mul_p_q <= '0;
					if (op_q == OP_APPLY && known_q) begin
						if (!axis_q) begin
							ox_q    <= o_sat;
							axis_q  <= 1'b1;
							mul_a_q <= PW'(mean_y_q);
							mul_b_q <= 24'(ratio);
							state_q <= S_MUL;
						end else begin
							oy_q     <= o_sat;
							status_q <= ST_APPLIED;
							state_q  <= S_OUT;
						end
					end else if (op_q == OP_APPLY) begin
						// learning a new key from the divider result
						if (!axis_q) begin
							mean_x_q  <= learned;
							axis_q    <= 1'b1;
							div_n_q   <= {magy, {(NW-14){1'b0}}};
							div_neg_q <= dy[13];
							div_r_q   <= '0;
							div_quo_q <= '0;
							div_cnt_q <= DCW'(NW);
							state_q   <= S_DIV;
						end else begin
							mean_y_q <= learned;
							state_q  <= S_WR;
						end
					end else begin
						unique case (phase_q)
							PH_MEAN: begin
								if (axis_q)
									mean_y_q <= new_mean;
								else
									mean_x_q <= new_mean;
								mul_a_q <= PW'(ad);
								mul_b_q <= ad24;
								phase_q <= PH_SQ;
								state_q <= S_MUL;
							end
							PH_SQ: begin
								mul_a_q <= PW'(vdiff);
								mul_b_q <= 24'(wt);
								phase_q <= PH_VAR;
								state_q <= S_MUL;
							end
							PH_VAR: begin
								if (!axis_q) begin
									var_x_q <= new_var;
									axis_q  <= 1'b1;
									mul_a_q <= PW'(ey_m);
									mul_b_q <= 24'(wt);
									phase_q <= PH_MEAN;
									state_q <= S_MUL;
								end else begin
									var_y_q <= new_var;
									if (cnt_q != 16'hFFFF)
										cnt_q <= cnt_q + 1'b1;
									state_q <= S_WR;
								end
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_WR: begin
					valid_q[addr_q] <= 1'b1;
					known_q <= 1'b1;
					state_q <= S_OUT;
					if (op_q == OP_APPLY) begin
						var_x_q  <= '0;
						var_y_q  <= '0;
						cnt_q    <= 16'd1;
						status_q <= ST_LEARNED;
					end else begin
						status_q <= ST_UPDATED;
					end
				end
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a learned key writes zeros and one, so the write beat must carry them
	// hence the new-key path zeroes var and count before S_WR above
	assign busy         = state_q != S_IDLE;
	assign done         = state_q == S_OUT;
	assign status       = status_q;
	assign out_x        = ox_q;
	assign out_y        = oy_q;
	assign mean_x       = known_q ? mean_x_q : '0;
	assign mean_y       = known_q ? mean_y_q : '0;
	assign spread_x     = known_q ? var_x_q : '0;
	assign spread_y     = known_q ? var_y_q : '0;
	assign sample_count = known_q ? cnt_q : '0;

endmodule

// ===== hw/rtl/koet_checker.sv =====
`include "key_offset_ema_table_top_macros.svh"

module koet_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [2:0] status
);
	import koet_pkg::*;

	logic clear_seen;
	assign clear_seen = done && (status == ST_CLEARED);

	`KOET_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
	`KOET_ASSERT_NEXT(a_done_pulse, done, !done && !busy, "result strobe not a single cycle")
	`KOET_ASSERT_NOW(a_done_busy, done, busy, "result shown while idle")
	`KOET_ASSERT_NOW(a_fall_done, $fell(busy), $past(done) || $past(clear_seen), "busy fell early")

endmodule

bind key_offset_ema_table_top koet_checker u_koet_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.status (status)
);
